@@ rtl/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// Operation codes, stream widths and the operand and result records that
// pass between the top level and the sequencer.
// ----------------------------------------------------------------------------
package rau_pkg;

	// Stream widths
	localparam int S_DATA_W = 128;
	localparam int S_USER_W = 3;
	localparam int M_DATA_W = 72;

	// Operand magnitude, full-width intermediate and result widths
	localparam int OPND_W = 32;
	localparam int MAG_W  = 64;
	localparam int NUM_W  = 32;
	localparam int DEN_W  = 31;
	localparam int CNT_W  = 6;

	// Operation codes
	localparam logic [2:0] ACT_ADD = 3'd0;
	localparam logic [2:0] ACT_SUB = 3'd1;
	localparam logic [2:0] ACT_MUL = 3'd2;
	localparam logic [2:0] ACT_DIV = 3'd3;
	localparam logic [2:0] ACT_NEG = 3'd4;
	localparam logic [2:0] ACT_RCP = 3'd5;
	localparam logic [2:0] ACT_CMP = 3'd6;

	// Operands in sign-magnitude form, denominators already positive
	typedef struct packed {
		logic [2:0]        act;
		logic              an_neg;
		logic [OPND_W-1:0] an_mag;
		logic [OPND_W-1:0] ad_mag;
		logic              bn_neg;
		logic [OPND_W-1:0] bn_mag;
		logic [OPND_W-1:0] bd_mag;
	} rau_opnd_t;

	// One finished result
	typedef struct packed {
		logic               overflow;
		logic               is_equal;
		logic               is_less;
		logic [DEN_W-1:0]   res_den;
		logic [NUM_W-1:0]   res_num;
	} rau_res_t;

endpackage

@@ rtl/rational_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: fraction arithmetic with gcd reduction
// Adds, subtracts, multiplies, divides, negates, inverts or compares two
// fractions and returns the result in lowest terms with an overflow flag.
//
// Channel  Dir  Fields (lowest bit first)
// s_*      in   tdata: a_num, a_den, b_num, b_den; tuser: action
// m_*      out  tdata: res_num, res_den, is_less, is_equal, overflow, 6 zero bits
//
// One request at a time: s_tready is high only while the sequencer is idle.
// Compare ends after its products and their sum; arithmetic takes two or three
// products, a binary gcd on 64-bit values and two restoring divisions on the
// shared adder. An undefined action goes straight to the final state.
// Reset is asynchronous and needs no clearing pass. A stalled m_tready holds
// the result and keeps the sequencer in its final state.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
	parameter int WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// a_num [31:0], a_den [63:32], b_num [95:64], b_den [127:96]
	input  logic [rau_pkg::S_DATA_W-1:0]  s_tdata,
	// action [2:0]
	input  logic [rau_pkg::S_USER_W-1:0]  s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// res_num [31:0], res_den [62:32], is_less [63], is_equal [64], overflow [65]
	output logic [rau_pkg::M_DATA_W-1:0]  m_tdata
);
	import rau_pkg::*;

	function automatic logic [OPND_W-1:0] mag_of(input logic [OPND_W-1:0] v);
		return v[OPND_W-1] ? (OPND_W'(0) - v) : v;
	endfunction

	logic [OPND_W-1:0] a_num, a_den, b_num, b_den;
	rau_opnd_t         opnd;
	rau_res_t          res;
	logic              core_idle, core_done, out_free, start;
	logic              m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	assign a_num = s_tdata[OPND_W-1:0];
	assign a_den = s_tdata[2*OPND_W-1:OPND_W];
	assign b_num = s_tdata[3*OPND_W-1:2*OPND_W];
	assign b_den = s_tdata[4*OPND_W-1:3*OPND_W];

	// zero denominator becomes one; a negative one moves its sign to the numerator
	always_comb begin
		opnd.act    = s_tuser;
		opnd.an_neg = a_num[OPND_W-1] ^ a_den[OPND_W-1];
		opnd.an_mag = mag_of(a_num);
		opnd.ad_mag = (a_den == '0) ? OPND_W'(1) : mag_of(a_den);
		opnd.bn_neg = b_num[OPND_W-1] ^ b_den[OPND_W-1];
		opnd.bn_mag = mag_of(b_num);
		opnd.bd_mag = (b_den == '0) ? OPND_W'(1) : mag_of(b_den);
	end

	assign s_tready = core_idle;
	assign start    = s_tvalid & core_idle;
	assign out_free = ~m_tvalid_q | m_tready;

	rau_core #(
		.WIDTH (WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.opnd     (opnd),
		.idle     (core_idle),
		.out_free (out_free),
		.done     (core_done),
		.res      (res)
	);

	// output register: load a finished result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (core_done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_done) begin
			m_tdata_q <= {{(M_DATA_W - $bits(rau_res_t)){1'b0}}, res};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ rtl/rau_alu.sv @@
// ----------------------------------------------------------------------------
// rau_alu: shared wide add/subtract unit
// One 64-bit adder with a borrow flag, used for the sign-magnitude sum,
// the gcd subtraction steps and the restoring division steps.
// ----------------------------------------------------------------------------
module rau_alu (
	input  logic [rau_pkg::MAG_W-1:0] a,
	input  logic [rau_pkg::MAG_W-1:0] b,
	input  logic                      sub,
	output logic [rau_pkg::MAG_W-1:0] sum,
	output logic                      borrow
);
	import rau_pkg::*;

	logic [MAG_W:0] full;

	// add, or add the complement plus one to subtract
	assign full   = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{MAG_W{1'b0}}, sub};
	assign sum    = full[MAG_W-1:0];
	assign borrow = sub & ~full[MAG_W];

endmodule

@@ rtl/rau_core.sv @@
// ----------------------------------------------------------------------------
// rau_core: sequencer of the rational arithmetic unit
// Forms products on one multiplier, combines them on the shared adder,
// finds the gcd by binary steps and reduces by two restoring divisions.
// ----------------------------------------------------------------------------
module rau_core #(
	parameter int WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  rau_pkg::rau_opnd_t  opnd,
	output logic                idle,
	input  logic                out_free,
	output logic                done,
	output rau_pkg::rau_res_t   res
);
	import rau_pkg::*;

	localparam logic [MAG_W-1:0] Limit = (64'd1 << (WIDTH - 1)) - 64'd1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL_X, ST_MUL_Y, ST_MUL_D, ST_COMB, ST_COMB_REV,
		ST_NORM, ST_GCD, ST_DIV_N, ST_DIV_D, ST_DONE
	} state_t;

	state_t            state_q;
	rau_opnd_t         op_q;
	logic [MAG_W-1:0]  x_q, y_q, d_q, u_q, v_q, rem_q;
	logic              x_neg_q, y_neg_q, d_neg_q;
	logic [CNT_W-1:0]  k_q, cnt_q;
	logic              less_q, equal_q;

	logic [OPND_W-1:0] mul_a, mul_b;
	logic              mul_neg;
	logic [MAG_W-1:0]  prod;
	logic [MAG_W-1:0]  alu_a, alu_b, alu_sum;
	logic              alu_sub, alu_borrow;
	logic [MAG_W-1:0]  dvd, trial;
	logic              two_terms, arith, ovf;

	assign two_terms = (op_q.act == ACT_ADD) || (op_q.act == ACT_SUB) || (op_q.act == ACT_CMP);
	assign arith     = (op_q.act != ACT_CMP) && (op_q.act <= ACT_RCP);

	// select multiplier operands and product sign
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		unique case (state_q)
			ST_MUL_X: begin
				case (op_q.act)
					ACT_MUL: begin
						mul_a = op_q.an_mag; mul_b = op_q.bn_mag;
						mul_neg = op_q.an_neg ^ op_q.bn_neg;
					end
					ACT_NEG: begin
						mul_a = op_q.an_mag; mul_b = OPND_W'(1); mul_neg = ~op_q.an_neg;
					end
					ACT_RCP: begin
						mul_a = op_q.ad_mag; mul_b = OPND_W'(1); mul_neg = 1'b0;
					end
					default: begin
						mul_a = op_q.an_mag; mul_b = op_q.bd_mag; mul_neg = op_q.an_neg;
					end
				endcase
			end
			ST_MUL_Y: begin
				mul_a   = op_q.ad_mag;
				mul_b   = op_q.bn_mag;
				mul_neg = op_q.bn_neg ^ (op_q.act != ACT_ADD);
			end
			ST_MUL_D: begin
				case (op_q.act)
					ACT_DIV: begin
						mul_a = op_q.ad_mag; mul_b = op_q.bn_mag; mul_neg = op_q.bn_neg;
					end
					ACT_NEG: begin
						mul_a = op_q.ad_mag; mul_b = OPND_W'(1); mul_neg = 1'b0;
					end
					ACT_RCP: begin
						mul_a = op_q.an_mag; mul_b = OPND_W'(1); mul_neg = op_q.an_neg;
					end
					default: begin
						mul_a = op_q.ad_mag; mul_b = op_q.bd_mag; mul_neg = 1'b0;
					end
				endcase
			end
			default: ;
		endcase
	end

	assign prod = {{(MAG_W-OPND_W){1'b0}}, mul_a} * {{(MAG_W-OPND_W){1'b0}}, mul_b};

	// division shifts the numerator or the denominator through the remainder
	assign dvd   = (state_q == ST_DIV_D) ? d_q : x_q;
	assign trial = {rem_q[MAG_W-2:0], dvd[MAG_W-1]};

	// route the shared adder
	always_comb begin
		alu_a   = u_q;
		alu_b   = v_q;
		alu_sub = 1'b1;
		unique case (state_q)
			ST_COMB: begin
				alu_a = x_q; alu_b = y_q; alu_sub = (x_neg_q != y_neg_q);
			end
			ST_COMB_REV: begin
				alu_a = y_q; alu_b = x_q; alu_sub = 1'b1;
			end
			ST_DIV_N, ST_DIV_D: begin
				alu_a = trial; alu_b = v_q; alu_sub = 1'b1;
			end
			default: ;
		endcase
	end

	rau_alu u_alu (
		.a      (alu_a),
		.b      (alu_b),
		.sub    (alu_sub),
		.sum    (alu_sum),
		.borrow (alu_borrow)
	);

	// fit check and result formatting
	assign ovf = arith && ((x_q > Limit) || (d_q > Limit));

	always_comb begin
		res          = '0;
		res.res_den  = DEN_W'(1);
		res.is_less  = less_q;
		res.is_equal = equal_q;
		res.overflow = ovf;
		if (arith && !ovf) begin
			res.res_num = (x_neg_q && (x_q != '0)) ? (NUM_W'(0) - x_q[NUM_W-1:0])
			                                        : x_q[NUM_W-1:0];
			res.res_den = d_q[DEN_W-1:0];
		end
	end

	assign idle = (state_q == ST_IDLE);
	assign done = (state_q == ST_DONE) && out_free;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q    <= opnd;
						less_q  <= 1'b0;
						equal_q <= 1'b0;
						state_q <= (opnd.act <= ACT_CMP) ? ST_MUL_X : ST_DONE;
					end
				end
				ST_MUL_X: begin
					x_q     <= prod;
					x_neg_q <= mul_neg;
					state_q <= two_terms ? ST_MUL_Y : ST_MUL_D;
				end
				ST_MUL_Y: begin
					y_q     <= prod;
					y_neg_q <= mul_neg;
					state_q <= ST_MUL_D;
				end
				ST_MUL_D: begin
					d_q     <= prod;
					d_neg_q <= mul_neg;
					state_q <= two_terms ? ST_COMB : ST_NORM;
				end
				// sign-magnitude sum; reverse the subtraction if it borrowed
				ST_COMB: begin
					if (alu_sub && alu_borrow) begin
						state_q <= ST_COMB_REV;
					end else begin
						x_q     <= alu_sum;
						state_q <= ST_NORM;
					end
				end
				ST_COMB_REV: begin
					x_q     <= alu_sum;
					x_neg_q <= y_neg_q;
					state_q <= ST_NORM;
				end
				// compare ends here; otherwise fix the denominator and seed the gcd
				ST_NORM: begin
					if (op_q.act == ACT_CMP) begin
						less_q  <= x_neg_q && (x_q != '0);
						equal_q <= (x_q == '0);
						state_q <= ST_DONE;
					end else begin
						if (d_q == '0) begin
							d_q <= MAG_W'(1);
							v_q <= MAG_W'(1);
						end else begin
							v_q <= d_q;
							if (d_neg_q) begin
								x_neg_q <= ~x_neg_q;
							end
						end
						u_q     <= x_q;
						k_q     <= '0;
						state_q <= ST_GCD;
					end
				end
				// one binary gcd step per cycle
				ST_GCD: begin
					if (u_q == '0) begin
						v_q     <= v_q << k_q;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV_N;
					end else if (!u_q[0] && !v_q[0]) begin
						u_q <= u_q >> 1;
						v_q <= v_q >> 1;
						k_q <= k_q + CNT_W'(1);
					end else if (!u_q[0]) begin
						u_q <= u_q >> 1;
					end else if (!v_q[0]) begin
						v_q <= v_q >> 1;
					end else if (!alu_borrow) begin
						u_q <= alu_sum;
					end else begin
						u_q <= v_q;
						v_q <= u_q;
					end
				end
				// restoring division, one quotient bit per cycle
				ST_DIV_N: begin
					x_q   <= {x_q[MAG_W-2:0], ~alu_borrow};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == {CNT_W{1'b1}}) begin
						rem_q   <= '0;
						state_q <= ST_DIV_D;
					end else begin
						rem_q <= alu_borrow ? trial : alu_sum;
					end
				end
				ST_DIV_D: begin
					rem_q <= alu_borrow ? trial : alu_sum;
					d_q   <= {d_q[MAG_W-2:0], ~alu_borrow};
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == {CNT_W{1'b1}}) begin
						state_q <= ST_DONE;
					end
				end
				// hold until the output register is free
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/rau_checker.sv @@
// ----------------------------------------------------------------------------
// rau_checker: port-level checks of the rational arithmetic unit
// Watches the stream ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module rau_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [rau_pkg::S_DATA_W-1:0]  s_tdata,
	input logic [rau_pkg::S_USER_W-1:0]  s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [rau_pkg::M_DATA_W-1:0]  m_tdata
);
	import rau_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or dropped");

	// one request in flight: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	// denominator is never zero
	a_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[62:32] != 31'd0)
		else $error("zero denominator");

	// overflow gives zero over one
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[65] |-> m_tdata[31:0] == 32'd0 && m_tdata[62:32] == 31'd1)
		else $error("overflow result not cleared");

	// less and equal are exclusive
	a_cmp_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[63] && m_tdata[64]))
		else $error("less and equal both set");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
